FILE: design/assert_macros.svh
// Assertion macros shared by the encoder position and speed design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define EPSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Next-cycle implication built on the check above.
`define EPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`EPSC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: design/epsc_pkg.sv
// Package: widths, constants, register codes and shared types of the encoder core.
`timescale 1ns / 1ps
package epsc_pkg;

	localparam int TIME_BITS       = 32;
	localparam int SPEED_FRAC_BITS = 8;
	localparam int TEETH_W         = 16;
	localparam int SPEED_W         = 32;

	// Speed numerator: 60e6 rpm*us, scaled by the fraction bits
	localparam longint unsigned SPEED_BASE = 64'd60000000;
	localparam int NUM_W = $clog2(SPEED_BASE + 1) + SPEED_FRAC_BITS;
	localparam logic [NUM_W-1:0] SPEED_NUM = NUM_W'(SPEED_BASE << SPEED_FRAC_BITS);

	// Divisor is interval times teeth
	localparam int PROD_W = TIME_BITS + TEETH_W;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	localparam logic [SPEED_W-1:0] SPEED_MAX   = '1;
	localparam logic [TEETH_W-1:0] TEETH_RESET = TEETH_W'(20);

	// APB register port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [0:0] {
		REG_TEETH  = 1'b0,
		REG_INVERT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [TEETH_W-1:0] teeth;
		logic               invert;
	} cfg_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} seq_state_t;

endpackage

FILE: design/epsc_if.sv
// Stream interfaces for encoder samples and position/speed results.
`timescale 1ns / 1ps
interface epsc_sample_if;
	logic        valid;
	logic        ready;
	logic        chan_a;
	logic        chan_b;
	logic [31:0] time_us;

	modport source (output valid, chan_a, chan_b, time_us, input ready);
	modport sink   (input valid, chan_a, chan_b, time_us, output ready);
endinterface

interface epsc_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position;
	logic               moving_forward;
	logic        [31:0] speed_rpm_q8;
	logic               edge_seen;

	modport source (output valid, position, moving_forward, speed_rpm_q8, edge_seen,
		input ready);
	modport sink   (input valid, position, moving_forward, speed_rpm_q8, edge_seen,
		output ready);
endinterface

FILE: design/encoder_position_and_speed_core.sv
// Top level: encoder edge detect, position count and speed sequencer.
`timescale 1ns / 1ps
// Usage
//   sample channel: chan_a, chan_b and a free-running microsecond timestamp.
//   result channel: one result per sample (position, direction, speed, edge flag).
//   Both are valid/ready; a transfer happens when valid and ready are high.
//   APB port: teeth_per_rev at 0x0, invert_direction at 0x4; write only while idle.
// Sequencing
//   A sample that needs no speed update passes from IDLE to DONE, which loads
//   its result into the output register once that is free. A sample with a
//   rising edge on A, or an elapsed time past a nonzero stored interval,
//   goes through MUL, which forms interval*teeth, then DIV, where the
//   bit-serial divider yields one quotient bit per cycle, then DONE. Zero
//   interval or zero teeth saturates the speed directly. The sample channel
//   takes one item at a time; ready is high while idle.
// Reset
//   arst_n clears position, timestamps, interval and speed to zero and
//   restores teeth_per_rev to 20 and invert_direction to 0.
// Stall
//   The result sits in an output register; a new sample may be taken while
//   it waits, and that sample's result holds until the register frees.
module encoder_position_and_speed_core import epsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	epsc_sample_if.sink       sample,
	epsc_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

`include "assert_macros.svh"

	cfg_t       cfg;
	div_ctrl_t  div_ctrl;
	div_stat_t  div_stat;
	logic [NUM_W-1:0] div_quot;

	seq_state_t state_q;

	logic                 prev_a_q;
	logic [TIME_BITS-1:0] last_edge_q;
	logic [31:0]          step_q;
	logic                 dir_q;
	logic [TIME_BITS-1:0] interval_q;
	logic [SPEED_W-1:0]   speed_q;
	logic                 edge_q;
	logic [TIME_BITS-1:0] dt_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 start_q;

	logic                 out_valid_q;
	logic signed [31:0]   out_pos_q;
	logic                 out_dir_q;
	logic [SPEED_W-1:0]   out_speed_q;
	logic                 out_edge_q;

	logic                 in_xfer;
	logic                 out_free;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] dt;
	logic                 rise;
	logic                 decay;

	epsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	epsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.divisor  (prod_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	function automatic logic [SPEED_W-1:0] sat_speed(input logic [NUM_W-1:0] q);
		if (64'(q) > 64'(SPEED_MAX))
			return SPEED_MAX;
		return SPEED_W'(q);
	endfunction

	// sample decode
	always_comb begin
		now   = TIME_BITS'(sample.time_us);
		dt    = now - last_edge_q;
		rise  = !prev_a_q && sample.chan_a;
		decay = (dt > interval_q) && (interval_q != '0);
	end

	assign sample.ready   = (state_q == ST_IDLE);
	assign in_xfer        = sample.valid && sample.ready;
	assign out_free       = !out_valid_q || result.ready;
	assign div_ctrl.start = start_q;

	// sequencer and encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_a_q    <= 1'b0;
			last_edge_q <= '0;
			step_q      <= '0;
			dir_q       <= 1'b0;
			interval_q  <= '0;
			speed_q     <= '0;
			edge_q      <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						prev_a_q <= sample.chan_a;
						edge_q   <= rise;
						state_q  <= ST_DONE;
						if (rise) begin
							step_q      <= sample.chan_b ? step_q + 32'd1 : step_q - 32'd1;
							dir_q       <= sample.chan_b ^ cfg.invert;
							interval_q  <= dt;
							last_edge_q <= now;
						end
						if (rise || decay) begin
							if (dt == '0 || cfg.teeth == '0)
								speed_q <= SPEED_MAX;
							else
								state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						speed_q <= sat_speed(div_quot);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divisor product and result payload
	always_ff @(posedge clk) begin
		if (in_xfer)
			dt_q <= dt;
		if (state_q == ST_MUL)
			prod_q <= PROD_W'(dt_q) * PROD_W'(cfg.teeth);
		if (state_q == ST_DONE && out_free) begin
			out_pos_q   <= step_q;
			out_dir_q   <= dir_q;
			out_speed_q <= speed_q;
			out_edge_q  <= edge_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.position       = out_pos_q;
	assign result.moving_forward = out_dir_q;
	assign result.speed_rpm_q8   = out_speed_q;
	assign result.edge_seen      = out_edge_q;

	`EPSC_ASSERT(a_start_idle_div, div_ctrl.start |-> !div_stat.busy, "divider started while busy")
	`EPSC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !sample.ready, "sample taken while busy")
	`EPSC_ASSERT(a_done_in_div, div_stat.done |-> (state_q == ST_DIV), "divider done outside DIV")

endmodule

FILE: design/epsc_regs.sv
// APB configuration registers: teeth per revolution and direction invert.
`timescale 1ns / 1ps
module epsc_regs import epsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [TEETH_W-1:0] teeth_q;
	logic               invert_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			teeth_q  <= TEETH_RESET;
			invert_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_TEETH:  teeth_q  <= pwdata[TEETH_W-1:0];
				REG_INVERT: invert_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TEETH:  prdata = APB_DW'(teeth_q);
			REG_INVERT: prdata = APB_DW'(invert_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.teeth  = teeth_q;
	assign cfg.invert = invert_q;

endmodule

FILE: design/epsc_div.sv
// Restoring divider, one quotient bit per cycle: speed numerator over interval*teeth.
`timescale 1ns / 1ps
module epsc_div import epsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctrl_t         ctrl,
	input  logic [PROD_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [NUM_W-1:0]  quotient
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;
	logic [PROD_W-1:0] den_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W:0]   rem_sh;
	logic [PROD_W:0]   rem_diff;
	logic              q_bit;

	// one shift/compare/subtract step
	always_comb begin
		rem_sh   = {rem_q, num_q[NUM_W-1]};
		rem_diff = rem_sh - {1'b0, den_q};
		q_bit    = (rem_sh >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			num_q  <= SPEED_NUM;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], q_bit};
			rem_q  <= q_bit ? rem_diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

endmodule

FILE: tb/encoder_speed_checker.sv
`timescale 1ns / 1ps
// Checker: watches the encoder channels and APB writes, predicts each result and compares it.
module encoder_speed_checker import epsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	epsc_sample_if            smp,
	epsc_result_if            res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                mismatch_count,
	output int                outstanding,
	output int                results_checked,
	output int                edges_predicted
);

	localparam longint unsigned RPM_US = 64'd60000000;

	typedef struct packed {
		logic signed [31:0] position;
		logic               forward;
		logic [SPEED_W-1:0] speed_q8;
		logic               rise;
	} enc_result_t;

	// register copy
	logic [TEETH_W-1:0]   teeth;
	logic                 invert;

	// predicted encoder state
	logic                 prev_a;
	logic [TIME_BITS-1:0] last_edge_t;
	logic [31:0]          steps;
	logic                 dir_flag;
	logic [TIME_BITS-1:0] interval;
	logic [SPEED_W-1:0]   speed;

	enc_result_t          expected_q[$];
	enc_result_t          want;
	logic [TIME_BITS-1:0] elapsed;
	logic                 rise;

	// rpm in Q8 from an interval in us; zero divisor or overflow saturates
	function automatic logic [SPEED_W-1:0] rpm_q8_of(input logic [TIME_BITS-1:0] dt,
		input logic [TEETH_W-1:0] tpr);
		logic [63:0] q;
		if (dt == '0 || tpr == '0)
			return SPEED_MAX;
		q = (RPM_US << SPEED_FRAC_BITS) / 64'(dt);
		q = q / 64'(tpr);
		if (q > 64'(SPEED_MAX))
			return SPEED_MAX;
		return q[SPEED_W-1:0];
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want_v);
		$display("MISMATCH at result %0d, %s: got %0h, want %0h", results_checked, what,
			got, want_v);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			teeth = TEETH_RESET;
			invert = 1'b0;
			prev_a = 1'b0;
			last_edge_t = '0;
			steps = '0;
			dir_flag = 1'b0;
			interval = '0;
			speed = '0;
			expected_q.delete();
			mismatch_count = 0;
			outstanding = 0;
			results_checked = 0;
			edges_predicted = 0;
		end else begin
			// result transfer: compare against the oldest prediction
			if (res.valid && res.ready) begin
				results_checked++;
				if (expected_q.size() == 0) begin
					note_mismatch("result with no sample pending", res.position, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (res.position !== want.position)
						note_mismatch("position", res.position, want.position);
					if (res.moving_forward !== want.forward)
						note_mismatch("moving_forward", 32'(res.moving_forward),
							32'(want.forward));
					if (res.speed_rpm_q8 !== want.speed_q8)
						note_mismatch("speed_rpm_q8", res.speed_rpm_q8, want.speed_q8);
					if (res.edge_seen !== want.rise)
						note_mismatch("edge_seen", 32'(res.edge_seen), 32'(want.rise));
				end
			end

			// sample transfer: step the predictor
			if (smp.valid && smp.ready) begin
				elapsed = smp.time_us - last_edge_t;
				rise = !prev_a && smp.chan_a;
				if (rise) begin
					edges_predicted++;
					if (smp.chan_b) begin
						steps = steps + 32'd1;
						dir_flag = 1'b1 ^ invert;
					end else begin
						steps = steps - 32'd1;
						dir_flag = invert;
					end
					interval = elapsed;
					speed = rpm_q8_of(elapsed, teeth);
					last_edge_t = smp.time_us;
				end
				prev_a = smp.chan_a;
				// decay once the gap outgrows the stored interval
				if (elapsed > interval && interval != '0)
					speed = rpm_q8_of(elapsed, teeth);
				want.position = steps;
				want.forward = dir_flag;
				want.speed_q8 = speed;
				want.rise = rise;
				expected_q.push_back(want);
			end

			// APB register write
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (reg_idx_t'(paddr[2]))
					REG_TEETH: begin
						teeth = pwdata[TEETH_W-1:0];
					end
					REG_INVERT: begin
						invert = pwdata[0];
					end
					default: begin
					end
				endcase
			end

			outstanding = expected_q.size();
		end
	end

endmodule

FILE: tb/encoder_position_and_speed_core_test.sv
`timescale 1ns / 1ps
// Testbench top: drives samples, APB settings and result back-pressure, then reports the verdict.
module encoder_position_and_speed_core_test;
	import epsc_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PAUSE_CYCLES = 4;
	localparam int TAIL_CYCLES  = 48;
	localparam int HOLD_LEN     = 300;
	localparam int PHASE_ITEMS  = 155;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	epsc_sample_if sample_ch();
	epsc_result_if result_ch();

	int mismatch_count;
	int outstanding;
	int results_checked;
	int edges_predicted;

	int send_idle = 13;
	int recv_idle = 84;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int samples_sent = 0;
	int settings_used = 1;
	int cycle_count;

	// quadrature walk state
	logic [31:0] walk_time;
	logic [1:0]  walk_q;
	logic        walk_dir;

	encoder_position_and_speed_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	encoder_speed_checker speed_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.smp             (sample_ch),
		.res             (result_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.edges_predicted (edges_predicted)
	);

	always #4 clk = ~clk;

	// result back-pressure: random idling, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_LEN - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// one sample transfer, with random idle cycles ahead of it
	task automatic send_sample(input logic a, input logic b, input logic [31:0] t);
		while ($urandom_range(99) < send_idle) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.chan_a <= a;
		sample_ch.chan_b <= b;
		sample_ch.time_us <= t;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// APB write: setup, then access until pready
	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering samples and wait until every result is back
	task automatic drain(input int pause);
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	// next sample: mostly legal quadrature steps, some repeats and noise
	task automatic walk_item();
		int unsigned pick;
		int unsigned tpick;
		logic a;
		logic b;
		pick = $urandom_range(99);
		if (pick < 4)
			walk_dir = ~walk_dir;
		if (pick < 85) begin
			walk_q = walk_dir ? walk_q + 2'd1 : walk_q - 2'd1;
			a = walk_q[0] ^ walk_q[1];
			b = walk_q[1];
		end else if (pick < 93) begin
			a = walk_q[0] ^ walk_q[1];
			b = walk_q[1];
		end else begin
			a = 1'($urandom_range(1));
			b = 1'($urandom_range(1));
		end
		tpick = $urandom_range(99);
		if (tpick < 60)
			walk_time = walk_time + $urandom_range(2000, 1);
		else if (tpick < 70)
			walk_time = walk_time;
		else if (tpick < 85)
			walk_time = walk_time + $urandom_range(200000, 2000);
		else if (tpick < 95)
			walk_time = walk_time + $urandom_range(3, 1);
		else
			walk_time = $urandom();
		send_sample(a, b, walk_time);
	endtask

	task automatic run_phase(input logic [TEETH_W-1:0] tpr, input logic inv,
		input int s_idle, input int r_idle, input bit long_hold);
		drain(PAUSE_CYCLES);
		reg_write(REG_TEETH, APB_DW'(tpr));
		reg_write(REG_INVERT, APB_DW'(inv));
		settings_used++;
		send_idle = s_idle;
		recv_idle = r_idle;
		if (long_hold)
			hold_requests++;
		repeat (PHASE_ITEMS) walk_item();
	endtask

	// run watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.chan_a <= 1'b0;
		sample_ch.chan_b <= 1'b0;
		sample_ch.time_us <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, zero interval, no decay before any interval
		send_sample(1'b0, 1'b0, 32'd0);
		send_sample(1'b1, 1'b0, 32'd0);
		send_sample(1'b0, 1'b1, 32'd100);
		send_sample(1'b1, 1'b1, 32'd1000);
		send_sample(1'b0, 1'b0, 32'd1500);
		send_sample(1'b0, 1'b0, 32'd3000);
		send_sample(1'b1, 1'b1, 32'd3000);
		// A held high is not an edge
		send_sample(1'b1, 1'b0, 32'd3001);
		send_sample(1'b0, 1'b0, 32'd3001);
		// timestamp wraps between consecutive rising edges on A
		send_sample(1'b1, 1'b0, 32'hFFFF_FF00);
		send_sample(1'b0, 1'b1, 32'hFFFF_FFFF);
		send_sample(1'b1, 1'b1, 32'h0000_0100);
		send_sample(1'b0, 1'b0, 32'h0000_0100);
		send_sample(1'b1, 1'b1, 32'h0000_0100);
		send_sample(1'b0, 1'b0, 32'h0010_0000);

		// one tooth, inverted: quotient overflow saturates
		drain(PAUSE_CYCLES);
		reg_write(REG_TEETH, APB_DW'(1));
		reg_write(REG_INVERT, APB_DW'(1));
		settings_used++;
		send_sample(1'b1, 1'b1, 32'h0010_0001);
		send_sample(1'b0, 1'b0, 32'h0010_0001);
		send_sample(1'b1, 1'b0, 32'h0010_0002);
		send_sample(1'b0, 1'b1, 32'h0010_0003);

		// invert cleared: flag holds until the next edge
		drain(PAUSE_CYCLES);
		reg_write(REG_INVERT, APB_DW'(0));
		settings_used++;
		send_sample(1'b0, 1'b1, 32'h0010_0004);
		send_sample(1'b1, 1'b1, 32'h0010_0010);

		// zero teeth: divisor zero saturates
		drain(PAUSE_CYCLES);
		reg_write(REG_TEETH, APB_DW'(0));
		settings_used++;
		send_sample(1'b0, 1'b0, 32'h0010_0020);
		send_sample(1'b1, 1'b0, 32'h0010_0040);
		send_sample(1'b0, 1'b1, 32'hFFFF_FFFF);

		// random quadrature walks across settings and idling modes
		walk_time = $urandom();
		walk_q = 2'd0;
		walk_dir = 1'b1;
		run_phase(16'hFFFF, 1'b0, 13, 84, 1'b0);
		run_phase(16'd1, 1'b1, 13, 84, 1'b0);
		run_phase(TEETH_W'($urandom()), 1'($urandom()), 84, 13, 1'b0);
		run_phase(16'd0, 1'b0, 84, 13, 1'b0);
		run_phase(TEETH_W'($urandom_range(400, 2)), 1'b1, 0, 0, 1'b1);
		run_phase(TEETH_RESET, 1'b0, 0, 0, 1'b0);

		drain(TAIL_CYCLES);
		$display("Run covered %0d samples, %0d with a rising edge on A, over %0d register settings",
			samples_sent, edges_predicted, settings_used);
		$display("Results compared: %0d, mismatches: %0d", results_checked, mismatch_count);
		if (mismatch_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
